// ===== design/overwrite_ring_log_tail_read_unit_assert.svh =====
// assertion macros used by the ring log tail read unit
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef OVERWRITE_RING_LOG_TAIL_READ_UNIT_ASSERT_SVH
`define OVERWRITE_RING_LOG_TAIL_READ_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge outside reset
`define ORL_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("orl assertion failed");

// implication checked at every edge outside reset
`define ORL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orl assertion failed");

`else

`define ORL_ASSERT_ALWAYS(label, clk, rst, expr)
`define ORL_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/orl_pkg.sv =====
// types and codes for the overwrite ring log with tail reads
// no dependencies
package orl_pkg;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int FIELD_W = 13;

  typedef struct packed {
    logic              func;
    logic [7:0]        put_byte;
    logic [FIELD_W-1:0] read_limit;
    logic [FIELD_W-1:0] read_position;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              byte_valid;
    logic              is_terminator;
    logic [FIELD_W-1:0] returned_count;
    logic [FIELD_W-1:0] fill_count;
  } res_item_t;

endpackage

// ===== design/overwrite_ring_log_tail_read_unit.sv =====
// Overwrite-oldest byte log ring with single-byte tail snapshot reads.
// Commands arrive on cmd (cmd_valid/cmd_ready), results leave on res
// (res_valid/res_ready), one result for every command item.
// A put item (func 0) appends put_byte; once the ring holds DEPTH bytes
// each put overwrites the oldest byte. A read item (func 1) looks at the
// newest min(fill, read_limit) bytes, oldest first, and returns the byte
// at read_position, or flags the terminator slot just past them when the
// count is below the limit. Every result carries the fill count.
// Throughput: one item per cycle unless the output stalls. Each item is one
// access of the byte RAM plus an update of the oldest index and fill count,
// done at acceptance. Each result passes the RAM read register, then the
// output register, before res_valid.
// Stalls: the RAM read stage and the output register each hold one item,
// so one more command is taken while a result waits; after that cmd_ready
// drops until res_ready returns.
// Reset: synchronous rst empties the log and the pipeline;
// RAM contents are not cleared, only written entries are ever returned.
// Depends on orl_pkg, orl_ram and overwrite_ring_log_tail_read_unit_assert.svh.
`include "overwrite_ring_log_tail_read_unit_assert.svh"

module overwrite_ring_log_tail_read_unit
  import orl_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

  logic [AW-1:0] oldest_index, oldest_index_next;
  logic [CW-1:0] stored_count, stored_count_next;

  logic          s1_valid;
  logic          s1_byte_valid;
  logic          s1_term;
  logic [FIELD_W-1:0] s1_count;
  logic [FIELD_W-1:0] s1_fill;
  logic [7:0]    rd_data;

  logic accept, res_load, full, is_read;
  logic [AW:0]   wsum, rsum;
  logic [AW-1:0] waddr, raddr;
  logic [XW-1:0] limit_x, stored_x, pos_x, count_x, offset_x, stored_next_x;
  logic          in_range, term;

  assign res_load  = s1_valid && (!res_valid || res_ready);
  assign cmd_ready = !s1_valid || res_load;
  assign accept    = cmd_valid && cmd_ready;
  assign is_read   = (cmd.func == FUNC_READ);
  assign full      = (stored_count == CW'(DEPTH));

  // put address: oldest when full, else one past the newest
  always_comb begin
    wsum = {1'b0, oldest_index} + (full ? '0 : {1'b0, stored_count[AW-1:0]});
    if (wsum >= (AW+1)'(DEPTH)) begin
      waddr = AW'(wsum - (AW+1)'(DEPTH));
    end else begin
      waddr = wsum[AW-1:0];
    end
  end

  // read address: oldest + (fill - count) + position, wrapped
  always_comb begin
    limit_x  = XW'(cmd.read_limit);
    stored_x = XW'(stored_count);
    pos_x    = XW'(cmd.read_position);
    count_x  = (stored_x < limit_x) ? stored_x : limit_x;
    in_range = (pos_x < count_x);
    term     = !in_range && (pos_x == count_x) && (count_x < limit_x);
    offset_x = stored_x - count_x + pos_x;
    rsum     = {1'b0, oldest_index} + {1'b0, offset_x[AW-1:0]};
    if (rsum >= (AW+1)'(DEPTH)) begin
      raddr = AW'(rsum - (AW+1)'(DEPTH));
    end else begin
      raddr = rsum[AW-1:0];
    end
  end

  always_comb begin
    oldest_index_next = oldest_index;
    stored_count_next = stored_count;
    if (accept && !is_read) begin
      if (full) begin
        oldest_index_next = (oldest_index == AW'(DEPTH - 1)) ? '0 : oldest_index + 1'b1;
      end else begin
        stored_count_next = stored_count + 1'b1;
      end
    end
  end

  assign stored_next_x = XW'(stored_count_next);

  orl_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && !is_read),
    .waddr (waddr),
    .wdata (cmd.put_byte),
    .re    (accept && is_read),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_index <= '0;
      stored_count <= '0;
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      oldest_index <= oldest_index_next;
      stored_count <= stored_count_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (res_load) begin
        s1_valid <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_valid <= is_read && in_range;
      s1_term       <= is_read && term;
      s1_count      <= is_read ? count_x[FIELD_W-1:0] : '0;
      s1_fill       <= stored_next_x[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.read_byte      <= s1_byte_valid ? rd_data : 8'd0;
      res.byte_valid     <= s1_byte_valid;
      res.is_terminator  <= s1_term;
      res.returned_count <= s1_count;
      res.fill_count     <= s1_fill;
    end
  end

  `ORL_ASSERT_ALWAYS(a_count_bound, clk, rst, stored_count <= CW'(DEPTH))
  `ORL_ASSERT_ALWAYS(a_oldest_bound, clk, rst, oldest_index <= AW'(DEPTH - 1))
  `ORL_ASSERT_IMPLY(a_oldest_moves_when_full, clk, rst,
    !$past(rst) && !$stable(oldest_index), $past(stored_count) == CW'(DEPTH))
  `ORL_ASSERT_IMPLY(a_count_steps, clk, rst, !$past(rst),
    stored_count == $past(stored_count) || stored_count == $past(stored_count) + 1'b1)
  `ORL_ASSERT_ALWAYS(a_flags_exclusive, clk, rst,
    !(res_valid && res.byte_valid && res.is_terminator))

endmodule

// ===== design/orl_ram.sv =====
// byte storage of the ring log: one write port, one registered read port
// depends on nothing; instantiated by overwrite_ring_log_tail_read_unit
module orl_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
